### hdl/rcc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the rank choice compatibility core.
// Depends on nothing; every other file refers to it by scoped names.
package rcc_pkg;

  localparam int NUM_TYPES    = 16;
  localparam int NUM_OPTIONS  = 15;
  localparam int ROW_LEN      = NUM_OPTIONS + 1;
  localparam int MASK_TYPES   = 16;
  localparam int MASK_OPTIONS = 15;

  localparam int CMD_W   = 1;
  localparam int TYPE_W  = 4;
  localparam int OPT_W   = 4;
  localparam int RANK_W  = 5;
  localparam int AVAIL_W = 15;
  localparam int MASK_W  = 16;
  localparam int COUNT_W = 5;

  // Cell position, wide enough for the largest type count.
  localparam int CELL_W = 7;
  // Common width for comparing small indexes against loop constants.
  localparam int CMP_W  = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef logic [RANK_W-1:0] rank_t;

  typedef struct packed {
    cmd_e                 command;
    logic [TYPE_W-1:0]    type_index;
    logic [OPT_W-1:0]     option_index;
    logic [RANK_W-1:0]    rank_value;
    logic [AVAIL_W-1:0]   available_mask;
    logic [OPT_W-1:0]     chosen_option;
    logic [MASK_W-1:0]    compat_mask;
    logic [COUNT_W-1:0]   compat_count;
  } item_t;

endpackage

### hdl/rcc_in_if.sv
`timescale 1ns / 1ps
// Input channel of the rank choice compatibility core: valid/ready plus payload.
// Depends on rcc_pkg for field widths.
interface rcc_in_if;
  logic                         valid;
  logic                         ready;
  logic [rcc_pkg::CMD_W-1:0]    command;
  logic [rcc_pkg::TYPE_W-1:0]   type_index;
  logic [rcc_pkg::OPT_W-1:0]    option_index;
  logic [rcc_pkg::RANK_W-1:0]   rank_value;
  logic [rcc_pkg::AVAIL_W-1:0]  available_mask;
  logic [rcc_pkg::OPT_W-1:0]    chosen_option;

  modport source (
    output valid, command, type_index, option_index, rank_value,
           available_mask, chosen_option,
    input  ready
  );

  modport sink (
    input  valid, command, type_index, option_index, rank_value,
           available_mask, chosen_option,
    output ready
  );
endinterface

### hdl/rcc_out_if.sv
`timescale 1ns / 1ps
// Result channel of the rank choice compatibility core: valid/ready plus payload.
// Depends on rcc_pkg for field widths.
interface rcc_out_if;
  logic                         valid;
  logic                         ready;
  logic [rcc_pkg::MASK_W-1:0]   compatible_mask;
  logic [rcc_pkg::COUNT_W-1:0]  compatible_count;

  modport source (
    output valid, compatible_mask, compatible_count,
    input  ready
  );

  modport sink (
    input  valid, compatible_mask, compatible_count,
    output ready
  );
endinterface

### hdl/rank_choice_compatibility_core.sv
`timescale 1ns / 1ps
// Path: an accepted query transaction is registered in cell 0, then in each
//   later cell in turn, then in the output register, where its result shows.
// Throughput: one transaction per cycle; the type-cell chain and the output
//   register advance together and stall as one when the result is not taken.
// Reset: clears the valid bits of the chain and of the output register; rank
//   rows are not cleared and stay undefined until loaded. Uses rcc_pkg, rcc_cell.
module rank_choice_compatibility_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  rcc_in_if.sink      in_i,
  rcc_out_if.source   out_o
);

  // Chain taps: index 0 is the incoming transaction, index t+1 leaves cell t.
  logic            chain_valid [rcc_pkg::NUM_TYPES+1];
  rcc_pkg::item_t  chain_item  [rcc_pkg::NUM_TYPES+1];

  logic                          advance;
  logic                          out_valid_q;
  logic [rcc_pkg::MASK_W-1:0]    out_mask_q;
  logic [rcc_pkg::COUNT_W-1:0]   out_count_q;
  logic                          last_query;

  // Advance the whole chain whenever the output register is empty or drained.
  assign advance  = !out_valid_q || out_o.ready;
  assign in_i.ready = advance;

  // Pack the input transaction; the running result starts empty.
  assign chain_valid[0] = in_i.valid;
  always_comb begin
    chain_item[0].command        = rcc_pkg::cmd_e'(in_i.command);
    chain_item[0].type_index     = in_i.type_index;
    chain_item[0].option_index   = in_i.option_index;
    chain_item[0].rank_value     = in_i.rank_value;
    chain_item[0].available_mask = in_i.available_mask;
    chain_item[0].chosen_option  = in_i.chosen_option;
    chain_item[0].compat_mask    = '0;
    chain_item[0].compat_count   = '0;
  end

  // One cell per customer type; loads and queries keep their order as they
  // pass, so a query only sees loads accepted before it.
  for (genvar t = 0; t < rcc_pkg::NUM_TYPES; t++) begin : g_cell
    rcc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (rcc_pkg::CELL_W'(t)),
      .advance_i  (advance),
      .valid_i    (chain_valid[t]),
      .item_i     (chain_item[t]),
      .valid_o    (chain_valid[t+1]),
      .item_o     (chain_item[t+1])
    );
  end

  // Drop load transactions at the end of the chain; only queries give results.
  assign last_query = chain_valid[rcc_pkg::NUM_TYPES] &&
                      (chain_item[rcc_pkg::NUM_TYPES].command == rcc_pkg::CMD_QUERY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= last_query;
    end
  end

  // Hold the result payload until it is taken.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_mask_q  <= chain_item[rcc_pkg::NUM_TYPES].compat_mask;
      out_count_q <= chain_item[rcc_pkg::NUM_TYPES].compat_count;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.compatible_mask  = out_mask_q;
  assign out_o.compatible_count = out_count_q;

  a_out_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($countones(out_mask_q) == int'(out_count_q)))
    else $error("result count disagrees with result mask");

  a_query_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && last_query) |=> out_valid_q)
    else $error("query transaction lost at the output register");

  a_load_gives_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !last_query) |=> !out_valid_q)
    else $error("result raised without a query transaction");

endmodule

### hdl/rcc_cell.sv
`timescale 1ns / 1ps
// One cell of the chain: holds the rank row of one customer type, applies
// loads for it and folds its consistency bit into passing queries. Uses rcc_pkg.
module rcc_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [rcc_pkg::CELL_W-1:0]  cell_idx_i,
  input  logic                        advance_i,
  input  logic                        valid_i,
  input  rcc_pkg::item_t              item_i,
  output logic                        valid_o,
  output rcc_pkg::item_t              item_o
);

  logic                  valid_q;
  rcc_pkg::item_t        item_q, item_d;
  rcc_pkg::rank_t        row_q [rcc_pkg::ROW_LEN];
  rcc_pkg::rank_t        chosen_rank;
  logic [rcc_pkg::ROW_LEN-1:0] beats;
  logic                  chosen_ok;
  logic                  consistent;
  logic                  load_hit;

  assign load_hit = valid_i && advance_i && (item_i.command == rcc_pkg::CMD_LOAD) &&
                    (rcc_pkg::CELL_W'(item_i.type_index) == cell_idx_i);

  // Rank of the chosen option in this row.
  always_comb begin
    chosen_rank = '0;
    for (int k = 0; k < rcc_pkg::ROW_LEN; k++) begin
      if (rcc_pkg::CMP_W'(item_i.chosen_option) == rcc_pkg::CMP_W'(k)) begin
        chosen_rank = row_q[k];
      end
    end
  end

  assign chosen_ok = rcc_pkg::CMP_W'(item_i.chosen_option) <=
                     rcc_pkg::CMP_W'(rcc_pkg::NUM_OPTIONS);

  // No-purchase beats the choice when strictly better ranked.
  assign beats[0] = row_q[0] < chosen_rank;

  // An option beats the choice when available, not chosen and strictly better.
  for (genvar k = 1; k < rcc_pkg::ROW_LEN; k++) begin : g_opt
    if (k <= rcc_pkg::MASK_OPTIONS) begin : g_masked
      assign beats[k] = item_i.available_mask[k-1] &&
                        (rcc_pkg::CMP_W'(item_i.chosen_option) != rcc_pkg::CMP_W'(k)) &&
                        (row_q[k] < chosen_rank);
    end else begin : g_unmasked
      assign beats[k] = 1'b0;
    end
  end

  assign consistent = chosen_ok && (beats == '0);

  always_comb begin
    item_d = item_i;
    if ((item_i.command == rcc_pkg::CMD_QUERY) && consistent &&
        (cell_idx_i < rcc_pkg::CELL_W'(rcc_pkg::MASK_TYPES))) begin
      item_d.compat_mask  = item_i.compat_mask | (rcc_pkg::MASK_W'(1) << cell_idx_i);
      item_d.compat_count = item_i.compat_count + rcc_pkg::COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      item_q <= item_d;
    end
  end

  // Rank row: undefined until loaded, so no reset.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < rcc_pkg::ROW_LEN; k++) begin
      if (load_hit &&
          (rcc_pkg::CMP_W'(item_i.option_index) == rcc_pkg::CMP_W'(k))) begin
        row_q[k] <= item_i.rank_value;
      end
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

  a_count_matches_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ($countones(item_q.compat_mask) == int'(item_q.compat_count)))
    else $error("cell count disagrees with mask");

  a_load_keeps_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && valid_i && (item_i.command == rcc_pkg::CMD_LOAD)) |=>
      (item_q.compat_mask == $past(item_i.compat_mask)) &&
      (item_q.compat_count == $past(item_i.compat_count)))
    else $error("load transaction altered the running result");

  a_stall_holds_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(valid_q) && $stable(item_q))
    else $error("cell moved while the chain was stalled");

endmodule
